@@ rtl/res_pkg.sv @@
`timescale 1ns / 1ps

package res_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned ID_W   = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SLOT_W = 6;

	// Default table depth and the reset value of the quiet window.
	localparam int unsigned       ENTRIES_DEF = 64;
	localparam logic [TIME_W-1:0] QUIET_RESET = 32'd8;

	// Request command codes.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// One table entry as it moves along the cell chain.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic start;
		logic step;
	} scan_ctrl_t;

	// Outcome of a finished scan.
	typedef struct packed {
		logic hit;
		logic play;
	} scan_flags_t;

endpackage

@@ rtl/res_ifs.sv @@
`timescale 1ns / 1ps

// Request channel: one tick or one query.
interface res_req_if;
	import res_pkg::*;

	logic            valid;
	logic            ready;
	logic            command;
	logic [ID_W-1:0] event_id;

	modport source (output valid, output command, output event_id, input ready);
	modport sink (input valid, input command, input event_id, output ready);
endinterface

// Response channel: one result per query.
interface res_rsp_if;
	import res_pkg::*;

	logic              valid;
	logic              ready;
	logic              play;
	logic              was_hit;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, output play, output was_hit, output slot_index, input ready);
	modport sink (input valid, input play, input was_hit, input slot_index, output ready);
endinterface

@@ rtl/res_cell.sv @@
`timescale 1ns / 1ps

module res_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            load,
	input  res_pkg::entry_t load_entry,
	input  res_pkg::entry_t next_entry,
	output res_pkg::entry_t entry
);
	import res_pkg::*;

	entry_t entry_q;

	// The cell takes its neighbor's entry while the chain rotates,
	// or a new entry when the sequencer writes this slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= next_entry;
		end else if (load) begin
			entry_q <= load_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/res_scan.sv @@
`timescale 1ns / 1ps

module res_scan #(
	parameter int unsigned ENTRIES = res_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  res_pkg::scan_ctrl_t         ctrl,
	input  logic [$clog2(ENTRIES)-1:0]  idx,
	input  res_pkg::entry_t             head,
	input  logic [res_pkg::ID_W-1:0]    query_id,
	input  logic [res_pkg::TIME_W-1:0]  tick,
	input  logic [res_pkg::TIME_W-1:0]  quiet,
	output res_pkg::scan_flags_t        flags,
	output logic [$clog2(ENTRIES)-1:0]  slot
);
	import res_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	logic              hit_q;
	logic              play_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [TIME_W-1:0] old_time_q;
	logic [IDX_W-1:0]  old_idx_q;

	logic [TIME_W-1:0] age;
	logic              expired;
	logic              match;
	logic              older;

	// Judge the entry at the head of the chain.
	assign age     = tick - head.stamp;
	assign expired = age > quiet;
	assign match   = head.id == query_id;
	assign older   = (idx == '0) || (head.stamp < old_time_q);

	// Control flags of the search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctrl.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctrl.step) begin
			if (!hit_q && match) begin
				hit_q <= 1'b1;
			end
			if (!free_q && (head.id == '0 || expired)) begin
				free_q <= 1'b1;
			end
		end
	end

	// Indexes and times captured along the search.
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (!hit_q && match) begin
				play_q    <= expired;
				hit_idx_q <= idx;
			end
			if (!free_q && (head.id == '0 || expired)) begin
				free_idx_q <= idx;
			end
			if (older) begin
				old_time_q <= head.stamp;
				old_idx_q  <= idx;
			end
		end
	end

	// A hit wins; otherwise the first free entry, then the oldest one.
	always_comb begin
		flags.hit  = hit_q;
		flags.play = hit_q ? play_q : 1'b1;
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (free_q) begin
			slot = free_idx_q;
		end else begin
			slot = old_idx_q;
		end
	end

endmodule

@@ rtl/repeat_event_suppressor.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Carries
// req       in         command (tick or query), event_id
// rsp       out        play, was_hit, slot_index
// cfg       in         cfg_we, cfg_wdata (quiet window)
//
// A tick request advances the tick counter and gives no response.
// A query request rotates the entries once around the cell chain past the scan unit at its
// head, one per cycle, then the DONE state writes the slot.
// Reset clears every cell at once; there is no clearing pass.
// A finished response waits in the output register while new requests are accepted;
// a following query holds in its write cycle until that register is free.
module repeat_event_suppressor #(
	parameter int unsigned ENTRIES = res_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	res_req_if.sink                       req,
	res_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [res_pkg::TIME_W-1:0]    cfg_wdata
);
	import res_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ID_W-1:0]   qid_q;
	logic [TIME_W-1:0] tick_q;
	logic [TIME_W-1:0] quiet_q;

	logic              out_valid_q;
	logic              play_q;
	logic              was_hit_q;
	logic [SLOT_W-1:0] slot_q;

	entry_t            cell_out [ENTRIES];
	entry_t            new_entry;
	scan_ctrl_t        ctrl;
	scan_flags_t       flags;
	logic [IDX_W-1:0]  slot;
	logic [IDX_W+SLOT_W-1:0] slot_ext;

	logic req_fire;
	logic shift;
	logic write;
	logic last;

	assign req.ready = state_q == ST_IDLE;
	assign req_fire  = req.valid && req.ready;
	assign shift     = state_q == ST_SCAN;
	assign last      = idx_q == IDX_W'(ENTRIES - 1);
	assign write     = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign ctrl.start = req_fire && (req.command == CMD_QUERY);
	assign ctrl.step  = shift;

	assign new_entry.id    = qid_q;
	assign new_entry.stamp = tick_q;

	// The cell chain; cell k takes from cell k+1, the last from the first.
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		localparam int unsigned NXT = (k + 1) % ENTRIES;

		res_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift),
			.load       (write && (slot == IDX_W'(k))),
			.load_entry (new_entry),
			.next_entry (cell_out[NXT]),
			.entry      (cell_out[k])
		);
	end

	res_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.idx      (idx_q),
		.head     (cell_out[0]),
		.query_id (qid_q),
		.tick     (tick_q),
		.quiet    (quiet_q),
		.flags    (flags),
		.slot     (slot)
	);

	// Quiet window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= QUIET_RESET;
		end else if (cfg_we) begin
			quiet_q <= cfg_wdata;
		end
	end

	// Sequencer and tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			tick_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.command == CMD_QUERY) begin
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							tick_q <= tick_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (write) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query id held for the whole scan.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			qid_q <= req.event_id;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (write) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, slot};

	always_ff @(posedge clk) begin
		if (write) begin
			play_q    <= flags.play;
			was_hit_q <= flags.hit;
			slot_q    <= slot_ext[SLOT_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.play       = play_q;
	assign rsp.was_hit    = was_hit_q;
	assign rsp.slot_index = slot_q;

endmodule
